FILE: rtl/hrlc_pkg.sv
`timescale 1ns / 1ps

package hrlc_pkg;

  // Parser phases, one-hot.
  typedef enum logic [7:0] {
    PH_SKIP        = 8'b0000_0001,
    PH_GAP_METHOD  = 8'b0000_0010,
    PH_METHOD      = 8'b0000_0100,
    PH_GAP_URI     = 8'b0000_1000,
    PH_URI         = 8'b0001_0000,
    PH_GAP_VERSION = 8'b0010_0000,
    PH_VERSION     = 8'b0100_0000,
    PH_DONE        = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD      = 2'd1,
    STATUS_NOT_IMPL = 2'd2
  } status_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  mcand;
    logic [3:0]  pos;
    logic [1:0]  vcand;
    logic        slash;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_SKIP, mcand: 8'hFF, pos: 4'd0, vcand: 2'b11, slash: 1'b0
  };

  localparam int NUM_METHODS = 8;
  localparam int GET_IDX     = 1;
  localparam logic [3:0] VERSION_LEN = 4'd8;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [7:0] METHOD_TBL [8][8] = '{
    '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
    '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
    '{"C", "O", "N", "N", "E", "C", "T", 8'h00}
  };

  localparam logic [3:0] METHOD_LEN [8] = '{
    4'd7, 4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7
  };

  localparam logic [7:0] VERSION_TBL [2][8] = '{
    '{"H", "T", "T", "P", "/", "1", ".", "1"},
    '{"H", "T", "T", "P", "/", "1", ".", "0"}
  };

endpackage

FILE: rtl/hrlc_step.sv
`timescale 1ns / 1ps

// Next-state and verdict logic for one message byte.
module hrlc_step (
  input  hrlc_pkg::parse_state_t cur_st,
  input  logic [7:0]             msg_byte,
  input  logic                   msg_last,
  output hrlc_pkg::parse_state_t nxt_st,
  output hrlc_pkg::status_t      status
);

  import hrlc_pkg::*;

  function automatic parse_state_t close_line(parse_state_t s);
    parse_state_t r;
    r = s;
    if (s.phase == PH_VERSION) begin
      if (s.pos != VERSION_LEN) r.vcand = 2'b00;
    end else if (s.phase != PH_DONE) begin
      r.mcand = 8'h00;
    end
    r.phase = PH_DONE;
    return r;
  endfunction

  logic         is_cr, is_lf, is_brk, is_space;
  logic [3:0]   mpos, vpos;
  logic [3:0]   mpos_inc, vpos_inc;
  logic [7:0]   mmatch, mlen_eq;
  logic [1:0]   vmatch;
  parse_state_t t, e;

  assign is_cr    = (msg_byte == CH_CR);
  assign is_lf    = (msg_byte == CH_LF);
  assign is_brk   = is_cr || is_lf || (msg_byte == CH_NUL);
  assign is_space = (msg_byte == CH_SPACE);

  // A token starting in a gap phase compares from position zero.
  assign mpos = (cur_st.phase == PH_METHOD)  ? cur_st.pos : 4'd0;
  assign vpos = (cur_st.phase == PH_VERSION) ? cur_st.pos : 4'd0;
  assign mpos_inc = (mpos == 4'hF) ? mpos : mpos + 4'd1;
  assign vpos_inc = (vpos == 4'hF) ? vpos : vpos + 4'd1;

  always_comb begin
    for (int i = 0; i < NUM_METHODS; i++) begin
      mmatch[i]  = (mpos < METHOD_LEN[i]) && (METHOD_TBL[i][mpos[2:0]] == msg_byte);
      mlen_eq[i] = (METHOD_LEN[i] == cur_st.pos);
    end
    for (int j = 0; j < 2; j++) begin
      vmatch[j] = !vpos[3] && (VERSION_TBL[j][vpos[2:0]] == msg_byte);
    end
  end

  always_comb begin
    t = cur_st;
    if (cur_st.phase == PH_DONE) begin
      t = cur_st;
    end else if (cur_st.phase == PH_SKIP && (is_cr || is_lf)) begin
      t = cur_st;
    end else if (is_brk) begin
      t = close_line(cur_st);
    end else begin
      unique case (cur_st.phase)
        PH_SKIP, PH_GAP_METHOD, PH_METHOD: begin
          if (is_space) begin
            if (cur_st.phase == PH_METHOD) begin
              t.mcand = cur_st.mcand & mlen_eq;
              t.phase = PH_GAP_URI;
            end else begin
              t.phase = PH_GAP_METHOD;
            end
          end else begin
            t.phase = PH_METHOD;
            t.mcand = cur_st.mcand & mmatch;
            t.pos   = mpos_inc;
          end
        end
        PH_GAP_URI: begin
          if (!is_space) begin
            t.phase = PH_URI;
            t.slash = (msg_byte == CH_SLASH);
          end
        end
        PH_URI: begin
          if (is_space) t.phase = PH_GAP_VERSION;
        end
        PH_GAP_VERSION, PH_VERSION: begin
          if (is_space) begin
            if (cur_st.phase == PH_VERSION) begin
              if (cur_st.pos != VERSION_LEN) t.vcand = 2'b00;
              t.phase = PH_DONE;
            end
          end else begin
            t.phase = PH_VERSION;
            t.vcand = cur_st.vcand & vmatch;
            t.pos   = vpos_inc;
          end
        end
        default: t = cur_st;
      endcase
    end
  end

  // The final byte closes the line and yields the verdict.
  always_comb begin
    e = close_line(t);
    if (e.mcand == 8'h00 || !e.slash || e.vcand == 2'b00) begin
      status = STATUS_BAD;
    end else if (e.mcand[GET_IDX]) begin
      status = STATUS_OK;
    end else begin
      status = STATUS_NOT_IMPL;
    end
    nxt_st = msg_last ? STATE_RESET : t;
  end

endmodule

FILE: rtl/http_request_line_checker.sv
`timescale 1ns / 1ps
// Timing: a word accepted at an edge is parsed from the input register in the next
// cycle; a last word's verdict reaches out_tvalid through the output register once free.
// Throughput: one word per cycle; the input register only holds while a last word
// waits for the single output register to drain.
// Reset: synchronous, active-low rst_n empties both registers and returns the parser
// to the start of a message.

module http_request_line_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] msg_byte
  input  logic       in_tlast,   // msg_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] status, [7:2] zero
);

  import hrlc_pkg::*;

  // Input register: one word of the message.
  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         s1_last_r;

  // Parser state carried between words of one message.
  parse_state_t st_r, st_nxt;

  // Output register holding one verdict.
  logic         out_valid_r, out_valid_nxt;
  status_t      out_status_r;

  status_t      step_status;
  logic         out_free;
  logic         s1_fire;
  logic         in_fire;

  hrlc_step u_step (
    .cur_st   (st_r),
    .msg_byte (s1_byte_r),
    .msg_last (s1_last_r),
    .nxt_st   (st_nxt),
    .status   (step_status)
  );

  // A last word needs the output register to be empty or draining; any
  // other word only updates the parser state, so it never stalls.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (s1_fire && s1_last_r) ? 1'b1
                       : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_fire && s1_last_r) out_status_r <= step_status;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r};

  // A held input word is always a last word blocked by a full output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |-> (s1_last_r && out_valid_r && !out_tready))
    else $error("input register stalled without a waiting verdict");

  // After the last word of a message the parser is back at its start.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (st_r == STATE_RESET))
    else $error("parser not restarted after message end");

  // A verdict is only loaded into an output register that is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |-> out_free)
    else $error("verdict overwrote an untaken result");

  // Only the three defined codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == STATUS_OK || out_status_r == STATUS_BAD ||
                     out_status_r == STATUS_NOT_IMPL))
    else $error("undefined status code");

endmodule
